// File: src/goi_pkg.sv
package goi_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  localparam logic signed [23:0] DRIFT_RESET = 24'sd282466;
  localparam logic [31:0] HEAD_GAIN = 32'd699971;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  // distance divide: the dividend is taken pre-shifted by 6, so 1e6 becomes 15625
  localparam logic [13:0] DIV_LO = 14'd15625;
  localparam logic [30:0] DIV_RECIP = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam logic [12:0] DIV_ROUND = 13'd7812;
  localparam int unsigned DIV_STEPS = 6;
  localparam int unsigned CNT_W = 6;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // input kinds on tuser
  localparam logic [1:0] KIND_VEL  = 2'd0;
  localparam logic [1:0] KIND_RATE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP, DP_LD_VEL, DP_LD_RATE, DP_LD_DT, DP_MUL_RD, DP_MUL_GLO,
    DP_MUL_GHI, DP_HEAD, DP_MUL_SD, DP_DIV, DP_CINIT, DP_CSTEP, DP_ROT,
    DP_MUL_X, DP_MUL_Y, DP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] idx;
  } goi_cmd_t;

  typedef struct packed {
    logic out_full;
  } goi_stat_t;

endpackage

// File: src/goi_ctrl.sv
module goi_ctrl #(
  parameter int unsigned CORDIC_STEPS = goi_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  goi_pkg::goi_stat_t stat,
  output goi_pkg::goi_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_H1, ST_GLO, ST_GHI, ST_HEAD, ST_SD, ST_DIV, ST_CINIT,
    ST_CSTEP, ST_ROT, ST_MX, ST_MY, ST_PUB
  } state_t;

  state_t state;
  logic [goi_pkg::CNT_W-1:0] cnt;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.op = goi_pkg::DP_NOP;
    cmd.idx = cnt[4:0];
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            goi_pkg::KIND_VEL:  cmd.op = goi_pkg::DP_LD_VEL;
            goi_pkg::KIND_RATE: cmd.op = goi_pkg::DP_LD_RATE;
            goi_pkg::KIND_TICK: cmd.op = goi_pkg::DP_LD_DT;
            default:            cmd.op = goi_pkg::DP_NOP;
          endcase
        end
      end
      ST_H1:    cmd.op = goi_pkg::DP_MUL_RD;
      ST_GLO:   cmd.op = goi_pkg::DP_MUL_GLO;
      ST_GHI:   cmd.op = goi_pkg::DP_MUL_GHI;
      ST_HEAD:  cmd.op = goi_pkg::DP_HEAD;
      ST_SD:    cmd.op = goi_pkg::DP_MUL_SD;
      ST_DIV:   cmd.op = goi_pkg::DP_DIV;
      ST_CINIT: cmd.op = goi_pkg::DP_CINIT;
      ST_CSTEP: cmd.op = goi_pkg::DP_CSTEP;
      ST_ROT:   cmd.op = goi_pkg::DP_ROT;
      ST_MX:    cmd.op = goi_pkg::DP_MUL_X;
      ST_MY:    cmd.op = goi_pkg::DP_MUL_Y;
      ST_PUB:   cmd.op = stat.out_full ? goi_pkg::DP_NOP : goi_pkg::DP_PUB;
      default:  cmd.op = goi_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_kind == goi_pkg::KIND_TICK) state <= ST_H1;
        end
        ST_H1:   state <= ST_GLO;
        ST_GLO:  state <= ST_GHI;
        ST_GHI:  state <= ST_HEAD;
        ST_HEAD: state <= ST_SD;
        ST_SD: begin
          state <= ST_DIV;
          cnt <= '0;
        end
        ST_DIV: begin
          if (cnt == goi_pkg::CNT_W'(goi_pkg::DIV_STEPS - 1)) state <= ST_CINIT;
          else cnt <= cnt + 1'b1;
        end
        ST_CINIT: begin
          state <= ST_CSTEP;
          cnt <= '0;
        end
        ST_CSTEP: begin
          if (cnt == goi_pkg::CNT_W'(CORDIC_STEPS - 1)) state <= ST_ROT;
          else cnt <= cnt + 1'b1;
        end
        ST_ROT: state <= ST_MX;
        ST_MX:  state <= ST_MY;
        ST_MY:  state <= ST_PUB;
        ST_PUB: begin
          if (!stat.out_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/goi_dpath.sv
module goi_dpath (
  input  logic                clk,
  input  logic                rst,
  input  goi_pkg::goi_cmd_t   cmd,
  output goi_pkg::goi_stat_t  stat,
  input  logic                cfg_wr_en,
  input  logic signed [23:0]  cfg_wr_data,
  input  logic signed [23:0]  in_velocity,
  input  logic signed [23:0]  in_rate,
  input  logic [19:0]         in_dt,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [47:0]         out_x,
  output logic [47:0]         out_y,
  output logic [31:0]         out_heading
);

  logic signed [23:0] drift_rate;
  logic signed [23:0] speed_held;
  logic signed [23:0] rate_held;
  logic [31:0] heading_acc;
  logic signed [47:0] x_acc;
  logic signed [47:0] y_acc;
  logic [19:0] dt;
  logic [43:0] m;
  logic [63:0] t;
  logic [47:0] num;
  logic [13:0] rem;
  logic [15:0] q_dig;
  logic dist_neg;
  logic [1:0] quad;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic signed [33:0] cs, sn;

  logic [23:0] rate_mag, speed_mag;
  logic [31:0] cs_mag, sn_mag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic signed [24:0] rate_diff;
  logic [29:0] div_val;
  logic [29:0] q_prod;
  logic signed [33:0] xs, ys;
  logic signed [32:0] atan_v;
  logic [63:0] head_rnd;
  logic [63:0] dx_rnd;
  logic signed [25:0] dd;
  logic signed [49:0] acc_sel, acc_sum;
  logic signed [47:0] acc_sat;
  logic prod_neg;
  logic [1:0] h_quad;
  logic [31:0] h_res;

  assign rate_mag  = rate_held[23] ? 24'(-rate_held) : rate_held;
  assign speed_mag = speed_held[23] ? 24'(-speed_held) : speed_held;
  assign cs_mag = 32'(cs[33] ? -cs : cs);
  assign sn_mag = 32'(sn[33] ? -sn : sn);

  // shared multiplier; the divide's digit product q_prod is formed apart
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      goi_pkg::DP_MUL_RD: begin
        mul_a = {8'd0, rate_mag};
        mul_b = {12'd0, dt};
      end
      goi_pkg::DP_MUL_GLO: begin
        mul_a = m[31:0];
        mul_b = goi_pkg::HEAD_GAIN;
      end
      goi_pkg::DP_MUL_GHI: begin
        mul_a = {20'd0, m[43:32]};
        mul_b = goi_pkg::HEAD_GAIN;
      end
      goi_pkg::DP_MUL_SD: begin
        mul_a = {8'd0, speed_mag};
        mul_b = {12'd0, dt};
      end
      goi_pkg::DP_DIV: begin
        mul_a = {2'd0, div_val};
        mul_b = {1'b0, goi_pkg::DIV_RECIP};
      end
      goi_pkg::DP_MUL_X: begin
        mul_a = num[31:0];
        mul_b = cs_mag;
      end
      goi_pkg::DP_MUL_Y: begin
        mul_a = num[31:0];
        mul_b = sn_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign rate_diff = {in_rate[23], in_rate} - {drift_rate[23], drift_rate};
  assign head_rnd = t + 64'd536870912;
  // base 2^16 long division, one reciprocal multiply per digit
  assign div_val = {rem, num[47:32]};
  assign q_prod = {14'd0, q_dig} * {16'd0, goi_pkg::DIV_LO};
  assign xs = cx >>> cmd.idx;
  assign ys = cy >>> cmd.idx;
  assign atan_v = $signed({3'd0, goi_pkg::ATAN_TAB[cmd.idx]});
  assign h_quad = 2'((heading_acc + 32'h2000_0000) >> 30);
  assign h_res = heading_acc - {h_quad, 30'd0};

  // rounded position step and saturating add
  assign dx_rnd = mul_p + (64'd1 << 37);
  assign prod_neg = dist_neg ^ ((cmd.op == goi_pkg::DP_MUL_X) ? cs[33] : sn[33]);
  assign dd = prod_neg ? -$signed({1'b0, dx_rnd[62:38]}) : $signed({1'b0, dx_rnd[62:38]});
  assign acc_sel = (cmd.op == goi_pkg::DP_MUL_X) ? 50'(x_acc) : 50'(y_acc);
  assign acc_sum = acc_sel + 50'(dd);
  always_comb begin
    if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111) acc_sat = acc_sum[47:0];
    else if (acc_sum[49]) acc_sat = {1'b1, 47'd0};
    else acc_sat = {1'b0, {47{1'b1}}};
  end

  assign stat.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_rate <= goi_pkg::DRIFT_RESET;
      speed_held <= '0;
      rate_held <= '0;
      heading_acc <= '0;
      x_acc <= '0;
      y_acc <= '0;
      rem <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) drift_rate <= cfg_wr_data;
      if (cmd.op == goi_pkg::DP_PUB) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        goi_pkg::DP_LD_VEL: speed_held <= in_velocity;
        goi_pkg::DP_LD_RATE: begin
          if (rate_diff[24] != rate_diff[23])
            rate_held <= rate_diff[24] ? 24'sh800000 : 24'sh7fffff;
          else
            rate_held <= rate_diff[23:0];
        end
        goi_pkg::DP_LD_DT:   dt <= in_dt;
        goi_pkg::DP_MUL_RD:  m <= mul_p[43:0];
        goi_pkg::DP_MUL_GLO: t <= mul_p;
        goi_pkg::DP_MUL_GHI: t <= t + {mul_p[31:0], 32'd0};
        goi_pkg::DP_HEAD: begin
          if (rate_held[23]) heading_acc <= heading_acc - head_rnd[61:30];
          else heading_acc <= heading_acc + head_rnd[61:30];
        end
        goi_pkg::DP_MUL_SD: begin
          // (speed * dt * 256 + 500000) / 64, the dropped low bits never carry
          num <= {3'd0, mul_p[42:0], 2'b00} + {35'd0, goi_pkg::DIV_ROUND};
          rem <= '0;
          dist_neg <= speed_held[23];
        end
        goi_pkg::DP_DIV: begin
          if (!cmd.idx[0]) begin
            q_dig <= mul_p[59:44];
          end else begin
            rem <= 14'(div_val - q_prod);
            num <= {num[31:0], q_dig};
          end
        end
        goi_pkg::DP_CINIT: begin
          quad <= h_quad;
          cz <= {h_res[31], h_res};
          cx <= goi_pkg::CORDIC_X0;
          cy <= '0;
        end
        goi_pkg::DP_CSTEP: begin
          if (!cz[32]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_v;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_v;
          end
        end
        goi_pkg::DP_ROT: begin
          case (quad)
            2'd0: begin cs <= cx;  sn <= cy;  end
            2'd1: begin cs <= -cy; sn <= cx;  end
            2'd2: begin cs <= -cx; sn <= -cy; end
            default: begin cs <= cy; sn <= -cx; end
          endcase
        end
        goi_pkg::DP_MUL_X: x_acc <= acc_sat;
        goi_pkg::DP_MUL_Y: y_acc <= acc_sat;
        goi_pkg::DP_PUB: begin
          out_x <= x_acc;
          out_y <= y_acc;
          out_heading <= heading_acc;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_head_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != goi_pkg::DP_HEAD) |=> $stable(heading_acc))
    else $error("heading moved outside its update step");
  a_pub_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == goi_pkg::DP_PUB) |=> out_valid)
    else $error("publish did not raise valid");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == goi_pkg::DP_DIV) |=> (rem < goi_pkg::DIV_LO))
    else $error("divider remainder out of range");
`endif

endmodule

// File: src/gyro_odometry_integrator_unit.sv
// flow: speed and rate words are loaded when accepted; a tick word runs 5
// multiply and heading steps, 6 steps of the reciprocal distance divide,
// cordic setup, the cordic iterations, 3 rotation and position update steps
// and a publish step that waits while the output is full
// input is held off from a tick's acceptance until its pose is published
// reset: synchronous, clears the heading and position accumulators, drift_rate returns to 282466
module gyro_odometry_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = goi_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // velocity, angular_rate, dt_us, zero pad
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // pos_x, pos_y, heading
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data
);

  goi_pkg::goi_cmd_t  cmd;
  goi_pkg::goi_stat_t stat;

  goi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  goi_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_velocity (s_tdata[23:0]),
    .in_rate     (s_tdata[47:24]),
    .in_dt       (s_tdata[67:48]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_x       (m_tdata[47:0]),
    .out_y       (m_tdata[95:48]),
    .out_heading (m_tdata[127:96])
  );

endmodule

// File: verif/goi_checker.sv
`timescale 1ns / 100ps

module goi_checker #(
  parameter int unsigned CORDIC_STEPS = goi_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,
  output int           fail_count,
  output int           poses_pending,
  output int           poses_checked
);

  // pos_x in the low bits, as on m_tdata
  typedef struct packed {
    logic [31:0] heading;
    logic [47:0] pos_y;
    logic [47:0] pos_x;
  } pose_t;

  pose_t expected_poses[$];

  // local copy of the integrator state
  longint      drift;
  longint      speed;
  longint      yaw_rate;
  logic [31:0] head;
  longint      x_pos;
  longint      y_pos;

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  // rounding shift of a signed product, half away from zero
  function automatic longint round_q38(input longint p);
    longint r;
    r = longint'((magnitude(p) + (64'd1 << 37)) >> 38);
    return (p < 0) ? -r : r;
  endfunction

  function automatic void cos_sin(input logic [31:0] h, output longint c, output longint s);
    logic [1:0]  q;
    logic [31:0] resid;
    longint      z, x, y, nx;
    q = 2'((h + 32'h2000_0000) >> 30);
    resid = h - {q, 30'b0};
    z = longint'($signed(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(goi_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(goi_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  task automatic integrate_tick(input logic [19:0] dt);
    logic [63:0] m, d;
    longint      distance, c, s;
    pose_t       p;
    m = magnitude(yaw_rate) * 64'(dt) * 64'd699971;
    d = (m + (64'd1 << 29)) >> 30;
    if (yaw_rate < 0) head = head - d[31:0];
    else head = head + d[31:0];
    m = magnitude(speed) * 64'(dt) * 64'd256;
    distance = longint'((m + 64'd500000) / 64'd1000000);
    if (speed < 0) distance = -distance;
    cos_sin(head, c, s);
    x_pos = clamp48(x_pos + round_q38(distance * c));
    y_pos = clamp48(y_pos + round_q38(distance * s));
    p.pos_x = x_pos[47:0];
    p.pos_y = y_pos[47:0];
    p.heading = head;
    expected_poses.push_back(p);
  endtask

  always @(posedge clk) begin
    pose_t  got, want;
    longint r;
    if (rst) begin
      drift = longint'(goi_pkg::DRIFT_RESET);
      speed = 0;
      yaw_rate = 0;
      head = '0;
      x_pos = 0;
      y_pos = 0;
      expected_poses.delete();
    end else begin
      if (cfg_wr_en) drift = longint'($signed(cfg_wr_data));
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          goi_pkg::KIND_VEL: speed = longint'($signed(s_tdata[23:0]));
          goi_pkg::KIND_RATE: begin
            r = longint'($signed(s_tdata[47:24])) - drift;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            yaw_rate = r;
          end
          goi_pkg::KIND_TICK: integrate_tick(s_tdata[67:48]);
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_poses.size() == 0) begin
          $error("pose word with none expected: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_poses.pop_front();
          poses_checked++;
          if (got.pos_x != want.pos_x) begin
            $error("pos_x expected %h got %h", want.pos_x, got.pos_x);
            fail_count++;
          end
          if (got.pos_y != want.pos_y) begin
            $error("pos_y expected %h got %h", want.pos_y, got.pos_y);
            fail_count++;
          end
          if (got.heading != want.heading) begin
            $error("heading expected %h got %h", want.heading, got.heading);
            fail_count++;
          end
        end
      end
    end
    poses_pending = expected_poses.size();
  end

  initial begin
    fail_count = 0;
    poses_pending = 0;
    poses_checked = 0;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 150;

  typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;   // velocity, angular_rate, dt_us, zero pad
  logic [1:0]   s_tuser = '0;   // op
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // pos_x, pos_y, heading
  logic         cfg_wr_en = 1'b0;
  logic [23:0]  cfg_wr_data = '0;

  int         fail_count, poses_pending, poses_checked;
  int         cycle_count = 0;
  int         words_sent = 0;
  idle_mode_t idle_mode = IDLE_NONE;

  gyro_odometry_integrator_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_wr_data
  );

  goi_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_wr_data,
    .fail_count, .poses_pending, .poses_checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: m_tready <= ($urandom_range(99) >= 61);
      IDLE_BOTH: m_tready <= ($urandom_range(99) >= 12);
      default:   m_tready <= 1'b1;
    endcase
  end

  task automatic send_word(input logic [1:0] op, input logic [23:0] vel,
                           input logic [23:0] rate, input logic [19:0] dt);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, dt, rate, vel};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (poses_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_drift(input logic [23:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [23:0] rand24();
    case ($urandom_range(9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'(signed'($urandom_range(2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(9))
      0: return 20'd0;
      1: return 20'hfffff;
      2, 3: return 20'($urandom);
      default: return 20'($urandom_range(40000));
    endcase
  endfunction

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) send_word(goi_pkg::KIND_VEL, rand24(), 24'($urandom), 20'($urandom));
    else if (pick < 50) send_word(goi_pkg::KIND_RATE, 24'($urandom), rand24(), 20'($urandom));
    else if (pick < 92) send_word(goi_pkg::KIND_TICK, 24'($urandom), 24'($urandom), rand_dt());
    else send_word(KIND_UNUSED, 24'($urandom), 24'($urandom), 20'($urandom));
  endtask

  initial begin
    logic [23:0] drift_settings [5];
    drift_settings = '{24'd282466, 24'h800000, 24'h7fffff, 24'd0, 24'h000000};
    drift_settings[4] = 24'($urandom);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, rate saturation against drift, unused op, zero dt
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'd0);
    send_word(goi_pkg::KIND_VEL, 24'h7fffff, '0, '0);
    send_word(goi_pkg::KIND_RATE, '0, 24'h800000, '0);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'hfffff);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'd0);
    send_word(goi_pkg::KIND_VEL, 24'h800000, '0, '0);
    send_word(goi_pkg::KIND_RATE, '0, 24'h7fffff, '0);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'd123456);
    send_word(KIND_UNUSED, 24'hffffff, 24'hffffff, 20'hfffff);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'd1);
    send_word(goi_pkg::KIND_VEL, 24'd65536, '0, '0);
    send_word(goi_pkg::KIND_RATE, '0, 24'd282466, '0);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'd16667);
    send_word(goi_pkg::KIND_RATE, '0, 24'd1_000_000, '0);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'd500000);
    send_word(goi_pkg::KIND_TICK, '0, '0, 20'hfffff);

    for (int phase = 0; phase < 5; phase++) begin
      write_drift(drift_settings[phase]);
      // rate extremes under every drift setting
      send_word(goi_pkg::KIND_RATE, '0, 24'h7fffff, '0);
      send_word(goi_pkg::KIND_TICK, '0, '0, 20'hfffff);
      send_word(goi_pkg::KIND_RATE, '0, 24'h800000, '0);
      send_word(goi_pkg::KIND_TICK, '0, '0, 20'hfffff);
      for (int m = 0; m < 4; m++) begin
        idle_mode = idle_mode_t'(m);
        for (int n = 0; n < 66; n++) random_word();
      end
      idle_mode = IDLE_NONE;
    end

    drain();
    $display("sent %0d words across 5 drift settings and 4 idle patterns", words_sent);
    $display("checked %0d pose words", poses_checked);
    if (fail_count == 0 && poses_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
